// ----- design/bcr_pkg.sv -----
package bcr_pkg;

  // coordinate width of the stored step and centre
  localparam int COORD_BITS = 11;
  // fixed field widths
  localparam int RADIUS_W = 10;
  localparam int CENTER_W = 11;
  localparam int PIX_W = 13;
  localparam int DEC_W = 16;
  // pixels per step and queue depth
  localparam int NUM_PIXELS = 8;
  localparam int PHASE_W = $clog2(NUM_PIXELS);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(NUM_PIXELS - 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // input kind codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // one octant step handed from front to back
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic                  done;
  } step_rec_t;

  // how one of the eight symmetric pixels is formed
  typedef struct packed {
    logic px_sel_y;
    logic px_neg;
    logic py_sel_y;
    logic py_neg;
  } pix_pattern_t;

  function automatic pix_pattern_t pixel_pattern(input logic [PHASE_W-1:0] phase);
    pix_pattern_t p;
    unique case (phase)
      3'd0: p = '{px_sel_y: 1'b0, px_neg: 1'b0, py_sel_y: 1'b1, py_neg: 1'b0};
      3'd1: p = '{px_sel_y: 1'b1, px_neg: 1'b0, py_sel_y: 1'b0, py_neg: 1'b0};
      3'd2: p = '{px_sel_y: 1'b1, px_neg: 1'b0, py_sel_y: 1'b0, py_neg: 1'b1};
      3'd3: p = '{px_sel_y: 1'b0, px_neg: 1'b0, py_sel_y: 1'b1, py_neg: 1'b1};
      3'd4: p = '{px_sel_y: 1'b0, px_neg: 1'b1, py_sel_y: 1'b1, py_neg: 1'b1};
      3'd5: p = '{px_sel_y: 1'b1, px_neg: 1'b1, py_sel_y: 1'b0, py_neg: 1'b1};
      3'd6: p = '{px_sel_y: 1'b1, px_neg: 1'b1, py_sel_y: 1'b0, py_neg: 1'b0};
      default: p = '{px_sel_y: 1'b0, px_neg: 1'b1, py_sel_y: 1'b1, py_neg: 1'b0};
    endcase
    return p;
  endfunction

  // width adaptors: zero extend, then keep the low bits
  function automatic logic [COORD_BITS-1:0] radius_to_coord(input logic [RADIUS_W-1:0] v);
    logic [COORD_BITS+RADIUS_W-1:0] w;
    w = {{COORD_BITS{1'b0}}, v};
    return w[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] center_to_coord(input logic [CENTER_W-1:0] v);
    logic [COORD_BITS+CENTER_W-1:0] w;
    w = {{COORD_BITS{1'b0}}, v};
    return w[COORD_BITS-1:0];
  endfunction

  function automatic logic [DEC_W-1:0] coord_to_dec(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS+DEC_W-1:0] w;
    w = {{DEC_W{1'b0}}, v};
    return w[DEC_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] coord_to_pix(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS+PIX_W-1:0] w;
    w = {{PIX_W{1'b0}}, v};
    return w[PIX_W-1:0];
  endfunction

endpackage

// ----- design/bcr_front.sv -----
module bcr_front import bcr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                kind,
  input  logic [RADIUS_W-1:0] radius,
  input  logic [CENTER_W-1:0] center_x,
  input  logic [CENTER_W-1:0] center_y,
  output logic                push,
  output step_rec_t           rec
);

  logic [COORD_BITS-1:0] step_x, step_y, origin_x, origin_y;
  logic [DEC_W-1:0]      decision;
  logic                  active;

  logic                  start;
  logic [COORD_BITS-1:0] ld_r, cur_x, cur_y, cur_cx, cur_cy;
  logic [COORD_BITS-1:0] step_x_next, step_y_next;
  logic [DEC_W-1:0]      cur_d, decision_next, x16, y16, r16;
  logic                  neg, done;
  logic [COORD_BITS:0]   x_inc, y_wide;

  // pick loaded values on start, stored ones on advance
  always_comb begin
    start  = (kind == KIND_START);
    ld_r   = radius_to_coord(radius);
    r16    = coord_to_dec(ld_r);
    cur_x  = start ? '0 : step_x;
    cur_y  = start ? ld_r : step_y;
    cur_cx = start ? center_to_coord(center_x) : origin_x;
    cur_cy = start ? center_to_coord(center_y) : origin_y;
    cur_d  = start ? (DEC_W'(3) - {r16[DEC_W-2:0], 1'b0}) : decision;
  end

  // midpoint decision update and done test
  always_comb begin
    neg    = cur_d[DEC_W-1];
    x16    = coord_to_dec(cur_x);
    y16    = coord_to_dec(cur_y);
    x_inc  = {1'b0, cur_x} + (COORD_BITS+1)'(1);
    y_wide = {1'b0, cur_y};
    if (neg) begin
      decision_next = cur_d + {x16[DEC_W-3:0], 2'b00} + DEC_W'(6);
      step_y_next   = cur_y;
      done          = (x_inc > y_wide);
    end else begin
      decision_next = cur_d + {x16[DEC_W-3:0] - y16[DEC_W-3:0], 2'b00} + DEC_W'(10);
      step_y_next   = cur_y - COORD_BITS'(1);
      done          = (x_inc >= y_wide);
    end
    step_x_next = x_inc[COORD_BITS-1:0];
  end

  assign push = accept && (start || active);
  assign rec  = '{x: cur_x, y: cur_y, cx: cur_cx, cy: cur_cy, done: done};

  // circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_x   <= '0;
      step_y   <= '0;
      decision <= '0;
      origin_x <= '0;
      origin_y <= '0;
      active   <= 1'b0;
    end else if (push) begin
      step_x   <= step_x_next;
      step_y   <= step_y_next;
      decision <= decision_next;
      origin_x <= cur_cx;
      origin_y <= cur_cy;
      active   <= !done;
    end
  end

endmodule

// ----- design/bcr_queue.sv -----
module bcr_queue import bcr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  step_rec_t push_rec,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output step_rec_t head_rec
);

  step_rec_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = entries[rd_ptr];

  // step record storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      priority if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- design/bcr_back.sv -----
module bcr_back import bcr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  step_rec_t               head_rec,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PIX_W-1:0] pixel_x,
  output logic signed [PIX_W-1:0] pixel_y,
  output logic                    last,
  output logic                    circle_done
);

  logic [PHASE_W-1:0] phase;
  logic               load;
  pix_pattern_t       pat;
  logic [PIX_W-1:0]   x13, y13, cx13, cy13, ax, ay, px, py;

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && (phase == PHASE_LAST);

  // form the pixel for the current phase
  always_comb begin
    pat  = pixel_pattern(phase);
    x13  = coord_to_pix(head_rec.x);
    y13  = coord_to_pix(head_rec.y);
    cx13 = coord_to_pix(head_rec.cx);
    cy13 = coord_to_pix(head_rec.cy);
    ax   = pat.px_sel_y ? y13 : x13;
    ay   = pat.py_sel_y ? y13 : x13;
    px   = pat.px_neg ? (cx13 - ax) : (cx13 + ax);
    py   = pat.py_neg ? (cy13 - ay) : (cy13 + ay);
  end

  // phase counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= phase + PHASE_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x     <= px;
      pixel_y     <= py;
      last        <= (phase == PHASE_LAST);
      circle_done <= head_rec.done;
    end
  end

endmodule

// ----- design/bresenham_circle_rasterizer.sv -----
// Midpoint circle rasteriser.
// Input channel (in_valid/in_ready): kind 0 starts a circle from radius and
// centre, kind 1 advances one octant step; an advance while no circle is in
// progress is swallowed and yields nothing.
// Output channel (out_valid/out_ready): each start or advance yields eight
// symmetric pixels, one per transaction, with last on the eighth and
// circle_done on all eight of the step that closes the circle.
// The front stage holds the circle state and computes the step in the cycle
// of acceptance; a two-entry queue carries step records to the back stage,
// which emits one pixel per cycle from a registered output while a step is
// queued and the receiver is not stalling; an input reaches the output through
// the queue and the output register. The front keeps taking transactions
// until the queue holds two pending steps.
// Reset empties the queue and output, clears the circle state to idle.
// A stalled receiver holds the current pixel; the queue fills and then
// in_ready drops until the back stage drains a step.
module bresenham_circle_rasterizer import bcr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic [RADIUS_W-1:0]     radius,
  input  logic [CENTER_W-1:0]     center_x,
  input  logic [CENTER_W-1:0]     center_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [PIX_W-1:0] pixel_x,
  output logic signed [PIX_W-1:0] pixel_y,
  output logic                    last,
  output logic                    circle_done
);

  logic      full, push, pop, head_valid;
  step_rec_t push_rec, head_rec;

  assign in_ready = !full;

  // front: accept and compute the step
  bcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (in_valid && in_ready),
    .kind     (kind),
    .radius   (radius),
    .center_x (center_x),
    .center_y (center_y),
    .push     (push),
    .rec      (push_rec)
  );

  // step queue between front and back
  bcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // back: emit eight pixels per step
  bcr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_rec    (head_rec),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last        (last),
    .circle_done (circle_done)
  );

endmodule

// ----- design/bcr_checker.sv -----
module bcr_checker import bcr_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [PIX_W-1:0] pixel_x,
  input logic signed [PIX_W-1:0] pixel_y,
  input logic                    last,
  input logic                    circle_done
);

  // reset leaves the output empty and the input open
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output not empty or input closed after reset");

  // a stalled pixel holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(last) && $stable(circle_done))
    else $error("stalled pixel changed");

  // the pixels of one step follow without a gap and share the done flag
  a_step_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && $stable(circle_done))
    else $error("step broken before its last pixel");

endmodule

bind bresenham_circle_rasterizer bcr_checker u_bcr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .last        (last),
  .circle_done (circle_done)
);
